// ===== hdl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// shared constants and types for the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int ACTION_W       = 3;
  localparam int POSITION_W     = 5;
  localparam int COUNT_OUT_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT_ASC  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INSERT_DESC = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_FIRST   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_POP_LAST    = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_AT   = 3'd6;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic take_left;
    logic take_new;
    logic take_right;
  } cell_ctl_t;

endpackage

// ===== hdl/olist_cell.sv =====
// ----------------------------------------------------------------------------
// olist_cell
// one list entry: holds a value, compares it against an incoming word and
// moves toward head or tail with its neighbors
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 desc,
  input  olist_pkg::value_t    item_value,
  input  olist_pkg::cell_ctl_t ctl,
  input  olist_pkg::value_t    new_value,
  input  olist_pkg::value_t    left_value,
  input  olist_pkg::value_t    right_value,
  output olist_pkg::value_t    value,
  output logic                 hit
);
  import olist_pkg::*;

  logic hit_next;

  always_comb begin
    if (desc) begin
      hit_next = !(item_value < value);
    end else begin
      hit_next = !(value < item_value);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit <= hit_next;
    end
    if (ctl.take_new) begin
      value <= new_value;
    end else if (ctl.take_left) begin
      value <= left_value;
    end else if (ctl.take_right) begin
      value <= right_value;
    end
  end

endmodule

// ===== hdl/ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// bounded list of signed words kept in a row of cells, with push, ordered
// insert, pop and remove at an index
// each word goes through accept, cell update and head/tail report in turn;
// the next word is taken only once the report is made, which waits for a free output
// a new word is taken while the previous result still waits at the output
// reset: synchronous, clears the entry count and the control state only
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
  parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [olist_pkg::ACTION_W-1:0]      action,
  input  olist_pkg::value_t                   item_value,
  input  logic [olist_pkg::POSITION_W-1:0]    position,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [olist_pkg::COUNT_OUT_W-1:0]   entry_count,
  output olist_pkg::value_t                   first_value,
  output olist_pkg::value_t                   last_value,
  output logic                                rejected
);
  import olist_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int WW = (CW > POSITION_W) ? CW : POSITION_W;
  localparam int LV = $clog2(LIST_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [ACTION_W-1:0]   act;
  value_t                val;
  logic [POSITION_W-1:0] pos;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  rej;
  logic                  rej_next;

  logic                  accept;
  logic                  load;
  logic                  desc;
  logic                  is_insert;
  logic                  out_free;

  value_t                vals [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] hits;
  cell_ctl_t             ctls [LIST_DEPTH];

  logic [LIST_DEPTH-1:0] h;
  logic [LIST_DEPTH-1:0] del;
  logic [LIST_DEPTH-1:0] pre [LV+1];
  logic [LIST_DEPTH-1:0] m;
  logic                  opens;
  logic                  closes;
  logic [IW-1:0]         last_idx;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign is_insert  = (action == ACT_INSERT_ASC) || (action == ACT_INSERT_DESC);
  assign load       = accept && is_insert;
  assign desc       = (action == ACT_INSERT_DESC);
  assign out_free   = !result_valid || result_ready;

  // operation decode and masks
  always_comb begin
    rej_next = 1'b0;
    opens    = 1'b0;
    closes   = 1'b0;
    h        = '0;
    del      = '0;
    unique case (act) inside
      ACT_PUSH_HEAD, ACT_PUSH_TAIL, ACT_INSERT_ASC, ACT_INSERT_DESC: begin
        if (count == CW'(LIST_DEPTH)) begin
          rej_next = 1'b1;
        end else begin
          opens = 1'b1;
        end
      end
      ACT_POP_FIRST, ACT_POP_LAST: begin
        if (count == '0) begin
          rej_next = 1'b1;
        end else begin
          closes = 1'b1;
        end
      end
      ACT_REMOVE_AT: begin
        if ((count == '0) || (WW'(pos) >= WW'(count))) begin
          rej_next = 1'b1;
        end else begin
          closes = 1'b1;
        end
      end
      default: begin
        rej_next = 1'b1;
      end
    endcase
    for (int i = 0; i < LIST_DEPTH; i++) begin
      case (act) inside
        ACT_PUSH_HEAD:  h[i] = (i == 0);
        ACT_PUSH_TAIL:  h[i] = (CW'(i) == count);
        ACT_INSERT_ASC, ACT_INSERT_DESC:
          h[i] = (hits[i] && (CW'(i) < count)) || (CW'(i) == count);
        default:        h[i] = 1'b0;
      endcase
      case (act)
        ACT_POP_FIRST: del[i] = 1'b1;
        ACT_REMOVE_AT: del[i] = (WW'(i) >= WW'(pos));
        default:       del[i] = 1'b0;
      endcase
    end
  end

  // prefix or over the hit flags, log depth
  always_comb begin
    pre[0] = h;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
    m = pre[LV];
  end

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ctls[i] = '0;
      if (state == S_EXEC) begin
        if (opens) begin
          ctls[i].take_new  = m[i] && ((i == 0) || !m[(i == 0) ? 0 : i - 1]);
          ctls[i].take_left = m[i] && !ctls[i].take_new;
        end else if (closes) begin
          ctls[i].take_right = del[i];
        end
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      olist_cell u_cell (
        .clk         (clk),
        .load        (load),
        .desc        (desc),
        .item_value  (item_value),
        .ctl         (ctls[g]),
        .new_value   (val),
        .left_value  (vals[(g == 0) ? 0 : g - 1]),
        .right_value (vals[(g == LIST_DEPTH - 1) ? g : g + 1]),
        .value       (vals[g]),
        .hit         (hits[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (opens) begin
      count_next = count + CW'(1);
    end else if (closes) begin
      count_next = count - CW'(1);
    end
  end

  assign last_idx = IW'(count - CW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC:   state_next = S_REPORT;
      S_REPORT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        count <= count_next;
      end
      if (state == S_REPORT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action;
      val <= item_value;
      pos <= position;
    end
    if (state == S_EXEC) begin
      rej <= rej_next;
    end
    if (state == S_REPORT && out_free) begin
      entry_count <= COUNT_OUT_W'(count);
      rejected    <= rej;
      if (count == '0) begin
        first_value <= '0;
        last_value  <= '0;
      end else begin
        first_value <= vals[0];
        last_value  <= vals[last_idx];
      end
    end
  end

endmodule
